>>> sv/wdce_pkg.sv
package wdce_pkg;

	// Default size of the window in which chunk headers are searched.
	localparam int unsigned WDCE_HEADER_WINDOW = 1024;

	// Entries in the queue between the front and the back; a power of two.
	localparam int unsigned WDCE_QUEUE_DEPTH = 2;
	localparam int unsigned WDCE_QPTR_W = $clog2(WDCE_QUEUE_DEPTH);
	localparam int unsigned WDCE_QCNT_W = $clog2(WDCE_QUEUE_DEPTH + 1);

	localparam logic [31:0] DATA_ID = 32'h6174_6164;
	localparam logic [32:0] RIFF_SKIP = 33'd12;
	localparam logic [33:0] HDR_LEN = 34'd8;

	localparam logic [2:0] KIND_FRAME = 3'd0;
	localparam logic [2:0] KIND_FINISHED = 3'd1;
	localparam logic [2:0] KIND_NOT_FOUND = 3'd2;
	localparam logic [2:0] KIND_EXCEEDS = 3'd3;
	localparam logic [2:0] KIND_TRUNC = 3'd4;

	// One file byte after the front has classified it by its offset.
	typedef struct packed {
		logic [7:0]  file_byte;
		logic        end_of_file;
		logic [31:0] pos;
	} wdce_item_t;

	typedef enum logic [3:0] {
		PH_SCAN = 4'b0001,
		PH_LOW  = 4'b0010,
		PH_HIGH = 4'b0100,
		PH_DONE = 4'b1000
	} wdce_phase_t;

endpackage

>>> sv/wdce_intf.sv
interface wdce_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       end_of_file;

	modport source(output valid, output file_byte, output end_of_file, input ready);
	modport sink(input valid, input file_byte, input end_of_file, output ready);
endinterface

interface wdce_result_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic               final_res;

	modport source(output valid, output kind, output left_sample, output right_sample,
		output final_res, input ready);
	modport sink(input valid, input kind, input left_sample, input right_sample,
		input final_res, output ready);
endinterface

interface wdce_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] file_size;

	modport source(output valid, output file_size, input ready);
	modport sink(input valid, input file_size, output ready);
endinterface

>>> sv/wdce_queue.sv
module wdce_queue import wdce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  wdce_item_t push_item,
	output logic       has_space,
	input  logic       pop,
	output logic       head_valid,
	output wdce_item_t head_item
);

	wdce_item_t                 entry_q [WDCE_QUEUE_DEPTH];
	logic [WDCE_QPTR_W-1:0]     wr_ptr_q;
	logic [WDCE_QPTR_W-1:0]     rd_ptr_q;
	logic [WDCE_QCNT_W-1:0]     count_q;

	assign has_space  = (count_q != WDCE_QCNT_W'(WDCE_QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> sv/wdce_front.sv
module wdce_front import wdce_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	wdce_byte_if.sink    byte_stream,
	input  logic         has_space,
	output logic         push,
	output wdce_item_t   push_item
);

	// Offset of the next byte within the current file.
	logic [31:0] pos_q;

	assign byte_stream.ready = has_space;
	assign push = byte_stream.valid && has_space;

	assign push_item.file_byte   = byte_stream.file_byte;
	assign push_item.end_of_file = byte_stream.end_of_file;
	assign push_item.pos         = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= byte_stream.end_of_file ? 32'd0 : pos_q + 32'd1;
		end
	end

endmodule

>>> sv/wdce_back.sv
module wdce_back import wdce_pkg::*; #(
	parameter int unsigned HEADER_WINDOW = WDCE_HEADER_WINDOW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   file_size,
	input  logic          head_valid,
	input  wdce_item_t    head_item,
	output logic          pop,
	wdce_result_if.source result_stream
);

	localparam logic [31:0] WIN_MAX = 32'(HEADER_WINDOW);

	wdce_phase_t      phase_q, phase_d;
	logic [32:0]      nhp_q, nhp_d;
	logic [7:0][7:0]  hdr_q, hdr_d;
	logic [31:0]      rem_q, rem_d;
	logic [7:0]       low_q, low_d;

	logic             out_valid_q;
	logic [2:0]       kind_q;
	logic [15:0]      sample_q;
	logic             final_q;

	logic [31:0]      window;
	logic [33:0]      diff;
	logic             in_hdr;
	logic [2:0]       lane;
	logic [7:0]       b;
	logic [31:0]      id;
	logic [31:0]      len;
	logic [33:0]      start;
	logic [33:0]      skip_end;
	logic [33:0]      skip_reach;
	logic [31:0]      rem_dec;
	logic             cur_nofit;

	logic             have;
	logic [2:0]       kind;
	logic [15:0]      sample;
	logic             fin;

	assign b       = head_item.file_byte;
	assign window  = (file_size < WIN_MAX) ? file_size : WIN_MAX;
	assign cur_nofit = ({1'b0, nhp_q} + HDR_LEN) > {2'b00, window};
	assign diff    = {2'b00, head_item.pos} - {1'b0, nhp_q};
	assign in_hdr  = !diff[33] && (diff[32:3] == '0);
	assign lane    = diff[2:0];
	assign id      = {hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
	assign len     = {hdr_q[7] | b, hdr_q[6], hdr_q[5], hdr_q[4]};
	assign start   = {1'b0, nhp_q} + HDR_LEN;
	assign skip_end = start + {2'b00, len} + {33'd0, len[0]};
	// Position just past the header that would follow the skipped chunk.
	assign skip_reach = {1'b0, nhp_q} + (HDR_LEN + HDR_LEN) + {2'b00, len} + {33'd0, len[0]};
	assign rem_dec = rem_q - 32'd1;

	assign pop = head_valid && (!out_valid_q || result_stream.ready);

	always_comb begin
		phase_d = phase_q;
		nhp_d   = nhp_q;
		hdr_d   = hdr_q;
		rem_d   = rem_q;
		low_d   = low_q;
		have    = 1'b0;
		kind    = KIND_FRAME;
		sample  = '0;
		fin     = 1'b0;
		unique case (phase_q)
			PH_SCAN: begin
				if (cur_nofit) begin
					have = 1'b1; kind = KIND_NOT_FOUND; fin = 1'b1; phase_d = PH_DONE;
				end else if (in_hdr) begin
					hdr_d[lane] = hdr_q[lane] | b;
					if (lane == 3'd7) begin
						hdr_d = '0;
						if (id == DATA_ID) begin
							if ((start + {2'b00, len}) > {2'b00, file_size}) begin
								have = 1'b1; kind = KIND_EXCEEDS; fin = 1'b1;
								phase_d = PH_DONE;
							end else if (len == '0) begin
								have = 1'b1; kind = KIND_FINISHED; fin = 1'b1;
								phase_d = PH_DONE;
							end else begin
								rem_d   = len;
								phase_d = PH_LOW;
							end
						end else begin
							nhp_d = skip_end[32:0];
							if (skip_reach > {2'b00, window}) begin
								have = 1'b1; kind = KIND_NOT_FOUND; fin = 1'b1;
								phase_d = PH_DONE;
							end
						end
					end
				end
			end
			PH_LOW: begin
				low_d   = b;
				rem_d   = rem_dec;
				phase_d = PH_HIGH;
				if (rem_dec == '0) begin
					have = 1'b1; kind = KIND_FINISHED; fin = 1'b1; phase_d = PH_DONE;
				end
			end
			PH_HIGH: begin
				sample  = {b, low_q};
				rem_d   = rem_dec;
				phase_d = PH_LOW;
				have    = 1'b1;
				kind    = KIND_FRAME;
				if (rem_dec == '0) begin
					fin = 1'b1; phase_d = PH_DONE;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		if (head_item.end_of_file) begin
			if (phase_d != PH_DONE) begin
				if (!(have && kind == KIND_FRAME)) begin
					sample = '0;
				end
				have = 1'b1;
				kind = KIND_TRUNC;
				fin  = 1'b1;
			end
			phase_d = PH_SCAN;
			nhp_d   = RIFF_SKIP;
			hdr_d   = '0;
			rem_d   = '0;
			low_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SCAN;
			nhp_q       <= RIFF_SKIP;
			hdr_q       <= '0;
			rem_q       <= '0;
			low_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result_stream.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				phase_q <= phase_d;
				nhp_q   <= nhp_d;
				hdr_q   <= hdr_d;
				rem_q   <= rem_d;
				low_q   <= low_d;
				if (have) begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && have) begin
			kind_q   <= kind;
			sample_q <= sample;
			final_q  <= fin;
		end
	end

	assign result_stream.valid        = out_valid_q;
	assign result_stream.kind         = kind_q;
	assign result_stream.left_sample  = sample_q;
	assign result_stream.right_sample = sample_q;
	assign result_stream.final_res    = final_q;

endmodule

>>> sv/wav_data_chunk_extractor_top.sv
// Channel        Direction  Beat contents
// byte_stream    in         file_byte, end_of_file
// result_stream  out        kind, left_sample, right_sample, final_res
// cfg            in         file_size (taken on every valid, ready is always high)
//
// One file byte is taken per cycle, back to back, while the queue has space; each result beat
// is held in the output register once the parser takes its byte. The parser step (wide adds
// and compares on the chunk header position) sets this rate.
// Reset (arst_n low) rearms the parser and clears file_size to zero.
// A stalled result only holds the output register; the two-entry queue keeps byte_stream
// ready until it is full, so each side can stall on its own.
module wav_data_chunk_extractor_top import wdce_pkg::*; #(
	parameter int unsigned HEADER_WINDOW = WDCE_HEADER_WINDOW
) (
	input  logic           clk,
	input  logic           arst_n,
	wdce_byte_if.sink      byte_stream,
	wdce_result_if.source  result_stream,
	wdce_cfg_if.sink       cfg
);

	// The file size register. It sets both the header search window and the bound that
	// the data chunk must fit in; it is read live by the parser.
	logic [31:0] file_size_q;

	// Beats travel from the front (which stamps each byte with its file offset) through
	// the queue to the back, which runs the chunk walk and sample pairing.
	logic        push;
	wdce_item_t  push_item;
	logic        has_space;
	logic        pop;
	logic        head_valid;
	wdce_item_t  head_item;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q <= '0;
		end else if (cfg.valid) begin
			file_size_q <= cfg.file_size;
		end
	end

	wdce_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_stream),
		.has_space   (has_space),
		.push        (push),
		.push_item   (push_item)
	);

	wdce_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.has_space  (has_space),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// The back end consumes one queued byte per cycle whenever its output register is
	// free or being drained, whether or not that byte produces a result.
	wdce_back #(
		.HEADER_WINDOW (HEADER_WINDOW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.file_size     (file_size_q),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.result_stream (result_stream)
	);

endmodule
